/* hdl/cba_pkg.sv */
// Shared types and constants for the circular buffer allocator.
package cba_pkg;

	localparam int LEN_W   = 17;
	localparam int OFF_W   = 16;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// Register map, indexed by word address
	localparam logic REG_BUFFER_LENGTH = 1'b0;

	localparam logic [LEN_W-1:0] BUFFER_LENGTH_RST = 17'h10000;
	localparam logic [LEN_W-1:0] ALLOC_BYTES_MAX   = 17'h1FFFF;

	typedef enum logic {
		ACT_ALLOC = 1'b0,
		ACT_FREE  = 1'b1
	} action_t;

	typedef struct packed {
		action_t          action;
		logic [LEN_W-1:0] length;
		logic [OFF_W-1:0] free_offset;
	} req_t;

	typedef struct packed {
		logic             granted;
		logic [OFF_W-1:0] alloc_offset;
		logic [LEN_W-1:0] allocated_bytes;
	} rsp_t;

endpackage

/* hdl/circular_buffer_allocator_top.sv */
// Ring-buffer space allocator: head/tail/wrap bookkeeping with a registered response.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------
//  req     | in        | req_valid/req_ready  | action, length, free_offset
//  rsp     | out       | rsp_valid/rsp_ready  | granted, alloc_offset, allocated_bytes
//  apb     | in        | psel/penable/pwrite  | paddr, pwdata, prdata (pready tied high)
//
// One request per cycle unless a response is held; it is answered in the next cycle.
// All decisions are made in one combinational pass over head, tail and wrap point.
// arst_n clears head, tail, wrap state and the response valid; buffer_length -> 65536.
// A held response blocks a new request only while rsp_ready is low.
module circular_buffer_allocator_top #(
	parameter int MAX_BYTES = 65536
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  cba_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output cba_pkg::rsp_t                 rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cba_pkg::PADDR_W-1:0]   paddr,
	input  logic [cba_pkg::PDATA_W-1:0]   pwdata,
	output logic [cba_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int CW = $clog2(MAX_BYTES + 1);
	localparam int AW = ((CW > cba_pkg::LEN_W) ? CW : cba_pkg::LEN_W) + 2;

	logic [cba_pkg::LEN_W-1:0] buf_len_q;
	logic [CW-1:0]             head_q, tail_q, wrap_pt_q;
	logic                      wrap_vld_q;
	logic                      rsp_valid_q;
	cba_pkg::rsp_t             rsp_q;

	logic          accept;
	logic          cfg_wr;
	logic [AW-1:0] head_x, tail_x, wrap_x, len_x, len_eff, max_x;
	logic [AW-1:0] head_n, tail_n, wrap_n;
	logic          wrap_vld_n;
	logic          fit_head, fit_zero;
	logic          granted;
	logic [AW-1:0] offset_x;
	logic [AW:0]   used_s;
	logic [cba_pkg::LEN_W-1:0] used;

	assign pready    = 1'b1;
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign cfg_wr    = psel && penable && pwrite && pready &&
		(paddr[2] == cba_pkg::REG_BUFFER_LENGTH);

	always_comb begin
		prdata = '0;
		if (paddr[2] == cba_pkg::REG_BUFFER_LENGTH) begin
			prdata = cba_pkg::PDATA_W'(buf_len_q);
		end
	end

	// Allocation decision and next state
	always_comb begin
		max_x   = AW'(MAX_BYTES);
		head_x  = AW'(head_q);
		tail_x  = AW'(tail_q);
		wrap_x  = AW'(wrap_pt_q);
		len_x   = AW'(req.length);
		len_eff = (AW'(buf_len_q) < max_x) ? AW'(buf_len_q) : max_x;

		fit_head = (head_x <= len_eff) && ((len_eff - head_x) >= len_x) &&
			!(wrap_vld_q && (wrap_x >= head_x) && (wrap_x < head_x + len_x));
		fit_zero = (tail_x >= len_x) && !(wrap_vld_q && (wrap_x < len_x));

		head_n     = head_x;
		tail_n     = tail_x;
		wrap_n     = wrap_x;
		wrap_vld_n = wrap_vld_q;
		granted    = 1'b0;
		offset_x   = '0;

		if (req.action == cba_pkg::ACT_ALLOC) begin
			if (fit_head) begin
				granted  = 1'b1;
				offset_x = head_x;
				head_n   = head_x + len_x;
			end else if (fit_zero) begin
				granted    = 1'b1;
				wrap_n     = tail_x;
				wrap_vld_n = 1'b1;
				tail_n     = '0;
				head_n     = len_x;
			end
		end else begin
			if (wrap_vld_q) begin
				if (req.free_offset == '0) begin
					wrap_vld_n = 1'b0;
					tail_n     = (len_x > max_x) ? max_x : len_x;
				end else begin
					wrap_n = (wrap_x + len_x > max_x) ? max_x : wrap_x + len_x;
				end
			end else begin
				tail_n = (tail_x + len_x > max_x) ? max_x : tail_x + len_x;
			end
			// everything released: rewind to the start
			if (!wrap_vld_n && (tail_n == head_n)) begin
				head_n = '0;
				tail_n = '0;
			end
		end

		used_s = $signed({1'b0, head_n}) - $signed({1'b0, tail_n});
		if (wrap_vld_n) begin
			used_s = used_s + $signed({1'b0, len_eff}) - $signed({1'b0, wrap_n});
		end
		if (used_s[AW]) begin
			used = '0;
		end else if (used_s > (AW+1)'(cba_pkg::ALLOC_BYTES_MAX)) begin
			used = cba_pkg::ALLOC_BYTES_MAX;
		end else begin
			used = cba_pkg::LEN_W'(used_s);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_len_q   <= cba_pkg::BUFFER_LENGTH_RST;
			head_q      <= '0;
			tail_q      <= '0;
			wrap_pt_q   <= '0;
			wrap_vld_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				buf_len_q <= pwdata[cba_pkg::LEN_W-1:0];
			end
			if (accept) begin
				head_q      <= CW'(head_n);
				tail_q      <= CW'(tail_n);
				wrap_pt_q   <= CW'(wrap_n);
				wrap_vld_q  <= wrap_vld_n;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.granted         <= granted;
			rsp_q.alloc_offset    <= cba_pkg::OFF_W'(offset_x);
			rsp_q.allocated_bytes <= used;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* hdl/cba_chk.sv */
// Port-level checks for the circular buffer allocator, bound to the top level.
module cba_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input cba_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input cba_pkg::rsp_t rsp
);

	// held response must not change
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready == (!rsp_valid || rsp_ready))
		else $error("request ready does not follow response slot");

	a_resp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("accepted request produced no response");

	a_free_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req.action == cba_pkg::ACT_FREE) |=> !rsp.granted)
		else $error("free request reported a grant");

	a_refused_offset: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.granted |-> rsp.alloc_offset == '0)
		else $error("refused request carries an offset");

endmodule

bind circular_buffer_allocator_top cba_chk u_cba_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

/* verif/tb_top.sv */
// Self-checking testbench for the circular buffer allocator: request/response and APB config.
`timescale 1ns / 100ps

module tb_top;
	import cba_pkg::*;

	localparam int          MAX_BYTES = 65536;
	localparam int unsigned LIMIT     = 200000;

	class alloc_scoreboard;
		int unsigned cap, buf_len, head, tail, wrap_pt;
		bit          wrap_on;
		rsp_t        expected_q[$];
		rsp_t        last_pred;
		int          errors, seen;

		function new(int unsigned c);
			cap = c;
			buf_len = BUFFER_LENGTH_RST;
			head = 0;
			tail = 0;
			wrap_pt = 0;
			wrap_on = 1'b0;
			errors = 0;
			seen = 0;
		endfunction

		function void set_buffer_length(logic [LEN_W-1:0] v);
			buf_len = v;
		endfunction

		function int unsigned eff_len();
			return (buf_len < cap) ? buf_len : cap;
		endfunction

		function int unsigned sat(int unsigned s);
			return (s > cap) ? cap : s;
		endfunction

		function bit hits_wrap(int unsigned start, int unsigned n);
			return wrap_on && wrap_pt >= start && wrap_pt < start + n;
		endfunction

		function bit is_empty();
			return !wrap_on && head == 0 && tail == 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// advance the allocator state by one request and queue its response
		function void note_request(req_t r);
			int unsigned n, lim;
			int          used;
			rsp_t        p;
			n = r.length;
			lim = eff_len();
			p = '0;
			if (r.action == ACT_ALLOC) begin
				if (head <= lim && lim - head >= n && !hits_wrap(head, n)) begin
					p.granted = 1'b1;
					p.alloc_offset = head[OFF_W-1:0];
					head = head + n;
				end else if (tail >= n && !hits_wrap(0, n)) begin
					p.granted = 1'b1;
					wrap_pt = tail;
					wrap_on = 1'b1;
					tail = 0;
					head = n;
				end
			end else begin
				if (wrap_on) begin
					// free at offset 0 means the wrapped region is the oldest one
					if (r.free_offset == '0) begin
						wrap_on = 1'b0;
						tail = sat(n);
					end else begin
						wrap_pt = sat(wrap_pt + n);
					end
				end else begin
					tail = sat(tail + n);
				end
				if (!wrap_on && tail == head) begin
					head = 0;
					tail = 0;
				end
			end
			used = int'(head) - int'(tail);
			if (wrap_on)
				used = used + int'(lim) - int'(wrap_pt);
			if (used < 0)
				used = 0;
			if (used > int'(ALLOC_BYTES_MAX))
				used = int'(ALLOC_BYTES_MAX);
			p.allocated_bytes = used[LEN_W-1:0];
			last_pred = p;
			expected_q.push_back(p);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 100)
				$display("ERROR: %s", msg);
		endtask

		task check_response(rsp_t got);
			rsp_t e;
			seen++;
			if (expected_q.size() == 0) begin
				report($sformatf("response %0d arrived with none expected", seen));
				return;
			end
			e = expected_q.pop_front();
			if (got.granted !== e.granted)
				report($sformatf("response %0d granted: exp %0d got %0d",
					seen, e.granted, got.granted));
			if (got.alloc_offset !== e.alloc_offset)
				report($sformatf("response %0d alloc_offset: exp %0d got %0d",
					seen, e.alloc_offset, got.alloc_offset));
			if (got.allocated_bytes !== e.allocated_bytes)
				report($sformatf("response %0d allocated_bytes: exp %0d got %0d",
					seen, e.allocated_bytes, got.allocated_bytes));
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_ready;
	req_t                req;
	logic                rsp_valid;
	logic                rsp_ready;
	rsp_t                rsp;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	alloc_scoreboard     sb;
	int                  send_pct;
	int                  stall_pct;
	int                  hold_left;
	int unsigned         cycles;
	logic [OFF_W-1:0]    live_off[$];
	logic [LEN_W-1:0]    live_len[$];

	circular_buffer_allocator_top #(.MAX_BYTES(MAX_BYTES)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
	end

	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles > LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// requests are noted before responses so a same-edge pair stays ordered
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				sb.note_request(req);
			if (rsp_valid && rsp_ready)
				sb.check_response(rsp);
		end
	end

	// receiver side: random stalls plus an optional long hold-off
	initial begin
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rsp_ready = 1'b0;
				hold_left = hold_left - 1;
			end else begin
				rsp_ready = !(stall_pct > 0 && $urandom_range(99) < stall_pct);
			end
		end
	end

	task automatic send_request(req_t r);
		while (send_pct > 0 && $urandom_range(99) < send_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req = r;
		req_valid = 1'b1;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
		if (r.action == ACT_ALLOC && sb.last_pred.granted) begin
			live_off.push_back(sb.last_pred.alloc_offset);
			live_len.push_back(r.length);
		end
		if (sb.is_empty()) begin
			live_off.delete();
			live_len.delete();
		end
	endtask

	task automatic do_req(action_t a, logic [LEN_W-1:0] n, logic [OFF_W-1:0] o);
		req_t r;
		r.action = a;
		r.length = n;
		r.free_offset = o;
		send_request(r);
	endtask

	task automatic drain();
		req_valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	// write, then read back in a back-to-back transfer
	task automatic write_buffer_length(logic [LEN_W-1:0] v);
		paddr = {REG_BUFFER_LENGTH, 2'b00};
		pwdata = PDATA_W'(v);
		pwrite = 1'b1;
		psel = 1'b1;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		sb.set_buffer_length(v);
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== PDATA_W'(v))
			sb.report($sformatf("buffer_length readback: exp %0d got %0d", v, prdata));
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	function automatic logic [LEN_W-1:0] pick_length(int unsigned lim);
		case ($urandom_range(19))
			0:       return '0;
			1:       return LEN_W'($urandom_range(131071));
			2, 3:    return LEN_W'($urandom_range(lim));
			4, 5, 6, 7, 8, 9:
				return LEN_W'($urandom_range(64, 1));
			default: return LEN_W'($urandom_range(lim / 8 + 1));
		endcase
	endfunction

	// mostly in-order alloc/free traffic, the rest arbitrary requests
	function automatic req_t random_request();
		req_t r;
		r.free_offset = '0;
		if ($urandom_range(99) < 75) begin
			if (live_len.size() > 0 && ($urandom_range(99) < 45 || live_len.size() > 12)) begin
				r.action = ACT_FREE;
				r.length = live_len.pop_front();
				r.free_offset = live_off.pop_front();
			end else begin
				r.action = ACT_ALLOC;
				r.length = pick_length(sb.eff_len());
			end
		end else begin
			r.action = action_t'($urandom_range(1));
			if ($urandom_range(3) == 0)
				r.length = LEN_W'($urandom_range(131071));
			else
				r.length = LEN_W'($urandom_range(sb.eff_len()));
			if ($urandom_range(1))
				r.free_offset = OFF_W'($urandom_range(65535));
		end
		return r;
	endfunction

	initial begin
		int                p, i;
		logic [LEN_W-1:0]  lengths [8];
		sb = new(MAX_BYTES);
		lengths = '{17'd65536, 17'd4096, 17'd131071, 17'd16, 17'd300, 17'd1, 17'd65535, 17'd0};
		send_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// full-size and zero-length allocs, refusal, full free back to empty
		do_req(ACT_ALLOC, 17'd0, 16'd0);
		do_req(ACT_ALLOC, 17'd65536, 16'd0);
		do_req(ACT_ALLOC, 17'd0, 16'd0);
		do_req(ACT_ALLOC, 17'd1, 16'd0);
		do_req(ACT_FREE, 17'd65536, 16'd0);
		// wrap to offset 0, covering the wrap point, free of the wrapped region
		do_req(ACT_ALLOC, 17'd40000, 16'd0);
		do_req(ACT_ALLOC, 17'd20000, 16'd0);
		do_req(ACT_FREE, 17'd40000, 16'd0);
		do_req(ACT_ALLOC, 17'd10000, 16'd0);
		do_req(ACT_ALLOC, 17'd35000, 16'd0);
		do_req(ACT_ALLOC, 17'd30000, 16'd0);
		do_req(ACT_ALLOC, 17'd0, 16'd0);
		do_req(ACT_FREE, 17'd20000, 16'd40000);
		do_req(ACT_FREE, 17'd10000, 16'd0);
		// over-free: tail saturates, in-use total clamps at zero
		do_req(ACT_FREE, 17'd131071, 16'hFFFF);
		do_req(ACT_FREE, 17'd0, 16'd0);
		drain();

		// head now past a shrunken buffer; wrap point saturation
		write_buffer_length(17'd1000);
		do_req(ACT_ALLOC, 17'd10, 16'd0);
		do_req(ACT_FREE, 17'd131071, 16'h8001);
		do_req(ACT_ALLOC, 17'd1001, 16'd0);
		drain();
		write_buffer_length(17'd0);
		do_req(ACT_ALLOC, 17'd0, 16'd0);
		do_req(ACT_ALLOC, 17'd1, 16'd0);
		do_req(ACT_FREE, 17'd0, 16'd0);
		drain();
		live_off.delete();
		live_len.delete();

		for (p = 0; p < 8; p++) begin
			if (p == 7)
				lengths[7] = LEN_W'($urandom_range(131071));
			write_buffer_length(lengths[p]);
			case (p % 4)
				0:       begin send_pct = 0;  stall_pct = 0;  end
				1:       begin send_pct = 49; stall_pct = 0;  end
				2:       begin send_pct = 0;  stall_pct = 49; end
				default: begin send_pct = 12; stall_pct = 12; end
			endcase
			// response side blocked for a while so requests back up
			if (p == 4)
				hold_left = 150;
			for (i = 0; i < 100; i++)
				send_request(random_request());
			drain();
		end

		send_pct = 0;
		stall_pct = 0;
		drain();
		repeat (4) @(negedge clk);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* sim.f */
hdl/cba_pkg.sv
hdl/circular_buffer_allocator_top.sv
hdl/cba_chk.sv
verif/tb_top.sv
